>>> rtl/nnh_pkg.sv
// ----------------------------------------------------------------------------
// nnh_pkg
// Types, constants and threshold tables of the grid nearest-neighbour
// histogram core.
// ----------------------------------------------------------------------------
package nnh_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int GRID_DIM   = 16;
    localparam int CELL_W     = $clog2(GRID_DIM);
    localparam int HIST_BINS  = 30;
    localparam int BIN_W      = 5;
    localparam int FRAC_BITS  = 8;
    localparam int COORD_W    = 20;
    localparam int SPAN_W     = COORD_W + 1;
    localparam int DSQ_W      = 42;
    localparam int CSIZE_W    = 16;
    localparam int NUM_THR    = 5;
    localparam int CFG_IDX_W  = 4;

    localparam logic [1:0] KIND_ALL = 2'd0;
    localparam logic [1:0] KIND_BOX = 2'd1;
    localparam logic [1:0] KIND_BIN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_ENABLE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z_LOW  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z_HIGH = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_LOW  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_HIGH = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X_LOW  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X_HIGH = 4'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_z;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_x;
        logic                      final_point;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       record_kind;
        logic [BIN_W-1:0] bin_index;
        logic [CNT_W-1:0] bin_count;
        logic [CNT_W-1:0] point_count;
        logic [DSQ_W-1:0] min_dist_sq;
        logic [CNT_W-1:0] count_below_quarter;
        logic [CNT_W-1:0] count_below_040;
        logic [CNT_W-1:0] count_below_half;
        logic [CNT_W-1:0] count_below_060;
        logic [CNT_W-1:0] count_below_one;
        logic             grid_error;
        logic             final_record;
    } t_out_item;

    typedef struct packed {
        logic [CELL_W-1:0]         cell_z;
        logic [CELL_W-1:0]         cell_y;
        logic [CELL_W-1:0]         cell_x;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef logic [DSQ_W-1:0] t_dsq_table [HIST_BINS];
    typedef logic [DSQ_W-1:0] t_thr_table [NUM_THR];

    // Bin k starts where the squared distance reaches (0.05 k)^2.
    function automatic t_dsq_table bin_table();
        t_dsq_table tbl;
        longint     num;
        for (int k = 0; k < HIST_BINS; k++) begin
            num    = longint'(k) * longint'(k) * (longint'(1) << (2 * FRAC_BITS));
            tbl[k] = DSQ_W'((num + 399) / 400);
        end
        return tbl;
    endfunction

    // A distance is below t hundredths when the squared distance is below these.
    function automatic t_thr_table thr_table();
        t_thr_table tbl;
        longint     hund [NUM_THR];
        longint     num;
        hund = '{25, 40, 50, 60, 100};
        for (int t = 0; t < NUM_THR; t++) begin
            num    = hund[t] * hund[t] * (longint'(1) << (2 * FRAC_BITS));
            tbl[t] = DSQ_W'((num + 9999) / 10000);
        end
        return tbl;
    endfunction

    localparam t_dsq_table BIN_THR  = bin_table();
    localparam t_thr_table DIST_THR = thr_table();

endpackage

>>> rtl/grid_nearest_neighbour_histogram_core.sv
// ----------------------------------------------------------------------------
// grid_nearest_neighbour_histogram_core
// Loads a point cloud, bins it into a grid over its bounding box and reports
// nearest-neighbour statistics for the cloud and for a box subset.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while busy is low. The item that carries
// final_point starts processing: a grid check, which on failure emits one
// error record; cell assignment; the neighbour search, where each point
// sweeps all stored points through the single read port; and result output.
// Results appear one per cycle on their strobe and must be taken as they
// come; busy stays high until the last one is on the result ports.
module grid_nearest_neighbour_histogram_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  nnh_pkg::t_in_item             i_item,
    output logic                          o_valid,
    output nnh_pkg::t_out_item            o_result,
    input  logic                          i_cfg_we,
    input  logic [nnh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nnh_pkg::COORD_W-1:0]   i_cfg_data
);
    import nnh_pkg::*;

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_ERR    = 4'd2;
    localparam logic [3:0] S_CELL   = 4'd3;
    localparam logic [3:0] S_CELLW  = 4'd4;
    localparam logic [3:0] S_IREAD  = 4'd5;
    localparam logic [3:0] S_ILOAD  = 4'd6;
    localparam logic [3:0] S_SWEEP  = 4'd7;
    localparam logic [3:0] S_DRAIN  = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;
    localparam logic [3:0] S_OUTALL = 4'd10;
    localparam logic [3:0] S_OUTBOX = 4'd11;
    localparam logic [3:0] S_OUTBIN = 4'd12;

    logic [3:0]                r_state;
    logic [CSIZE_W-1:0]        r_cell_size;
    logic                      r_box_en;
    logic signed [COORD_W-1:0] r_bnd [6];
    logic [CNT_W-1:0]          r_count;
    logic signed [COORD_W-1:0] r_min [3];
    logic signed [COORD_W-1:0] r_max [3];
    logic [ADDR_W-1:0]         r_k;
    logic                      r_wb;
    logic [ADDR_W-1:0]         r_wb_addr;
    logic [ADDR_W-1:0]         r_i;
    logic [ADDR_W-1:0]         r_j;
    logic                      r_rd_v;
    logic [ADDR_W-1:0]         r_rd_addr;
    logic [1:0]                r_drain;
    t_entry                    r_pt;
    logic [DSQ_W-1:0]          r_best;
    logic [DSQ_W-1:0]          r_min_all, r_min_box;
    logic [CNT_W-1:0]          r_thr_all [NUM_THR];
    logic [CNT_W-1:0]          r_thr_box [NUM_THR];
    logic [CNT_W-1:0]          r_boxn;
    logic [CNT_W-1:0]          r_hist [HIST_BINS];
    logic [BIN_W-1:0]          r_t;
    logic                      r_out_v;
    t_out_item                 r_out;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    t_entry            ram_wdata, ram_rdata;
    logic              dist_v;
    logic [DSQ_W-1:0]  dist_dsq;
    logic              accept, grid_err, in_box, last_n;
    logic [CSIZE_W-1:0] csize;
    logic [ADDR_W-1:0]  n_last;
    logic [BIN_W-1:0]   bin;
    logic [HIST_BINS-1:0] nz_mask;
    logic signed [COORD_W-1:0] pcoord [3];
    logic [CELL_W-1:0]  cells [3];

    function automatic logic [CELL_W-1:0] cell_of(input logic [SPAN_W-1:0] off,
                                                  input logic [CSIZE_W-1:0] c);
        logic [SPAN_W+CELL_W-1:0] rem;
        logic [SPAN_W+CELL_W-1:0] step;
        logic [CELL_W-1:0]        q;
        rem = (SPAN_W + CELL_W)'(off);
        q   = '0;
        for (int b = CELL_W - 1; b >= 0; b--) begin
            step = (SPAN_W + CELL_W)'(c) << b;
            if (rem >= step) begin
                rem  = rem - step;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [COORD_W-1:0] ram_wdata_coord(input int a);
        case (a)
            0:       return i_item.coord_z;
            1:       return i_item.coord_y;
            default: return i_item.coord_x;
        endcase
    endfunction

    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != S_LOAD);
    assign csize  = (r_cell_size == '0) ? CSIZE_W'(1) : r_cell_size;
    assign n_last = ADDR_W'(r_count - CNT_W'(1));
    assign pcoord = '{ram_rdata.z, ram_rdata.y, ram_rdata.x};

    always_comb begin
        logic [SPAN_W-1:0] span;
        logic [SPAN_W-1:0] off;
        grid_err = 1'b0;
        for (int a = 0; a < 3; a++) begin
            span = SPAN_W'(r_max[a]) - SPAN_W'(r_min[a]);
            if ((SPAN_W + CELL_W)'(span)
                >= (SPAN_W + CELL_W)'(csize) * (SPAN_W + CELL_W)'(GRID_DIM)) begin
                grid_err = 1'b1;
            end
            off      = SPAN_W'(pcoord[a]) - SPAN_W'(r_min[a]);
            cells[a] = cell_of(off, csize);
        end
    end

    always_comb begin
        in_box = r_box_en
                 && (r_pt.z >= r_bnd[0]) && (r_pt.z <= r_bnd[1])
                 && (r_pt.y >= r_bnd[2]) && (r_pt.y <= r_bnd[3])
                 && (r_pt.x >= r_bnd[4]) && (r_pt.x <= r_bnd[5]);
        bin = '0;
        for (int k = 1; k < HIST_BINS; k++) begin
            if (r_best >= BIN_THR[k]) begin
                bin = BIN_W'(k);
            end
        end
        for (int k = 0; k < HIST_BINS; k++) begin
            nz_mask[k] = (r_hist[k] != '0);
        end
        last_n = ((nz_mask >> r_t) >> 1) == '0;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[ADDR_W-1:0];
        ram_wdata = '{cell_z: '0, cell_y: '0, cell_x: '0,
                      z: i_item.coord_z, y: i_item.coord_y, x: i_item.coord_x};
        ram_raddr = r_j;
        if (accept && (r_count < CNT_W'(MAX_POINTS))) begin
            ram_we = 1'b1;
        end else if (r_wb) begin
            ram_we    = 1'b1;
            ram_waddr = r_wb_addr;
            ram_wdata = '{cell_z: cells[0], cell_y: cells[1], cell_x: cells[2],
                          z: ram_rdata.z, y: ram_rdata.y, x: ram_rdata.x};
        end
        case (r_state)
            S_CELL:  ram_raddr = r_k;
            S_IREAD: ram_raddr = r_i;
            default: ram_raddr = r_j;
        endcase
    end

    nnh_point_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    nnh_dist_pipe u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_rd_v),
        .i_addr       (r_rd_addr),
        .i_cand       (ram_rdata),
        .i_point      (r_pt),
        .i_point_addr (r_i),
        .o_valid      (dist_v),
        .o_dsq        (dist_dsq)
    );

    assign o_valid  = r_out_v;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cell_size <= CSIZE_W'(384);
            r_box_en    <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_bnd[2*a]   <= {1'b1, {(COORD_W-1){1'b0}}};
                r_bnd[2*a+1] <= {1'b0, {(COORD_W-1){1'b1}}};
            end
            r_count   <= '0;
            r_wb      <= 1'b0;
            r_rd_v    <= 1'b0;
            r_out_v   <= 1'b0;
            r_boxn    <= '0;
            r_min_all <= '1;
            r_min_box <= '1;
            for (int t = 0; t < NUM_THR; t++) begin
                r_thr_all[t] <= '0;
                r_thr_box[t] <= '0;
            end
            for (int k = 0; k < HIST_BINS; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            r_out_v <= 1'b0;
            r_wb    <= 1'b0;
            r_rd_v  <= 1'b0;
            r_out   <= '0;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CELL_SIZE:  r_cell_size <= i_cfg_data[CSIZE_W-1:0];
                    REG_BOX_ENABLE: r_box_en    <= i_cfg_data[0];
                    REG_BOX_Z_LOW:  r_bnd[0]    <= i_cfg_data;
                    REG_BOX_Z_HIGH: r_bnd[1]    <= i_cfg_data;
                    REG_BOX_Y_LOW:  r_bnd[2]    <= i_cfg_data;
                    REG_BOX_Y_HIGH: r_bnd[3]    <= i_cfg_data;
                    REG_BOX_X_LOW:  r_bnd[4]    <= i_cfg_data;
                    REG_BOX_X_HIGH: r_bnd[5]    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (dist_v && (dist_dsq < r_best)) begin
                r_best <= dist_dsq;
            end

            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (r_count < CNT_W'(MAX_POINTS)) begin
                            r_count <= r_count + CNT_W'(1);
                            for (int a = 0; a < 3; a++) begin
                                if (r_count == '0 || ram_wdata_coord(a) < r_min[a]) begin
                                    r_min[a] <= ram_wdata_coord(a);
                                end
                                if (r_count == '0 || ram_wdata_coord(a) > r_max[a]) begin
                                    r_max[a] <= ram_wdata_coord(a);
                                end
                            end
                        end
                        if (i_item.final_point) begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_k     <= '0;
                    r_state <= grid_err ? S_ERR : S_CELL;
                end
                S_ERR: begin
                    r_out_v             <= 1'b1;
                    r_out.record_kind   <= KIND_ALL;
                    r_out.point_count   <= r_count;
                    r_out.min_dist_sq   <= '1;
                    r_out.grid_error    <= 1'b1;
                    r_out.final_record  <= 1'b1;
                    r_count             <= '0;
                    r_state             <= S_LOAD;
                end
                S_CELL: begin
                    r_wb      <= 1'b1;
                    r_wb_addr <= r_k;
                    r_k       <= r_k + ADDR_W'(1);
                    if (r_k == n_last) begin
                        r_state <= S_CELLW;
                    end
                end
                S_CELLW: begin
                    r_i     <= '0;
                    r_state <= S_IREAD;
                end
                S_IREAD: begin
                    r_state <= S_ILOAD;
                end
                S_ILOAD: begin
                    r_pt    <= ram_rdata;
                    r_best  <= '1;
                    r_j     <= '0;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    r_rd_v    <= 1'b1;
                    r_rd_addr <= r_j;
                    r_j       <= r_j + ADDR_W'(1);
                    r_drain   <= '0;
                    if (r_j == n_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'd3) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_best < r_min_all) begin
                        r_min_all <= r_best;
                    end
                    for (int t = 0; t < NUM_THR; t++) begin
                        if (r_best < DIST_THR[t]) begin
                            r_thr_all[t] <= r_thr_all[t] + CNT_W'(1);
                            if (in_box) begin
                                r_thr_box[t] <= r_thr_box[t] + CNT_W'(1);
                            end
                        end
                    end
                    if (in_box) begin
                        r_boxn      <= r_boxn + CNT_W'(1);
                        r_hist[bin] <= r_hist[bin] + CNT_W'(1);
                        if (r_best < r_min_box) begin
                            r_min_box <= r_best;
                        end
                    end
                    r_i     <= r_i + ADDR_W'(1);
                    r_state <= (r_i == n_last) ? S_OUTALL : S_IREAD;
                end
                S_OUTALL: begin
                    r_out_v                   <= 1'b1;
                    r_out.record_kind         <= KIND_ALL;
                    r_out.point_count         <= r_count;
                    r_out.min_dist_sq         <= r_min_all;
                    r_out.count_below_quarter <= r_thr_all[0];
                    r_out.count_below_040     <= r_thr_all[1];
                    r_out.count_below_half    <= r_thr_all[2];
                    r_out.count_below_060     <= r_thr_all[3];
                    r_out.count_below_one     <= r_thr_all[4];
                    r_out.final_record        <= !(r_box_en && r_boxn != '0);
                    r_state <= (r_box_en && r_boxn != '0) ? S_OUTBOX : S_LOAD;
                end
                S_OUTBOX: begin
                    r_out_v                   <= 1'b1;
                    r_out.record_kind         <= KIND_BOX;
                    r_out.point_count         <= r_boxn;
                    r_out.min_dist_sq         <= r_min_box;
                    r_out.count_below_quarter <= r_thr_box[0];
                    r_out.count_below_040     <= r_thr_box[1];
                    r_out.count_below_half    <= r_thr_box[2];
                    r_out.count_below_060     <= r_thr_box[3];
                    r_out.count_below_one     <= r_thr_box[4];
                    r_t                       <= '0;
                    r_state                   <= S_OUTBIN;
                end
                S_OUTBIN: begin
                    if (nz_mask[r_t]) begin
                        r_out_v            <= 1'b1;
                        r_out.record_kind  <= KIND_BIN;
                        r_out.bin_index    <= r_t;
                        r_out.bin_count    <= r_hist[r_t];
                        r_out.final_record <= last_n;
                    end
                    r_t <= r_t + BIN_W'(1);
                    if (r_t == BIN_W'(HIST_BINS - 1)) begin
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase

            if ((r_state == S_OUTALL && !(r_box_en && r_boxn != '0))
                || (r_state == S_OUTBIN && r_t == BIN_W'(HIST_BINS - 1))) begin
                r_count   <= '0;
                r_boxn    <= '0;
                r_min_all <= '1;
                r_min_box <= '1;
                for (int t = 0; t < NUM_THR; t++) begin
                    r_thr_all[t] <= '0;
                    r_thr_box[t] <= '0;
                end
                for (int k = 0; k < HIST_BINS; k++) begin
                    r_hist[k] <= '0;
                end
            end
        end
    end

endmodule

>>> rtl/nnh_point_ram.sv
// ----------------------------------------------------------------------------
// nnh_point_ram
// Point store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module nnh_point_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [nnh_pkg::ADDR_W-1:0] i_waddr,
    input  nnh_pkg::t_entry           i_wdata,
    input  logic [nnh_pkg::ADDR_W-1:0] i_raddr,
    output nnh_pkg::t_entry           o_rdata
);
    import nnh_pkg::*;

    t_entry mem [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

>>> rtl/nnh_dist_pipe.sv
// ----------------------------------------------------------------------------
// nnh_dist_pipe
// Three-stage squared-distance pipeline between the current point and one
// candidate read from the point store.
// ----------------------------------------------------------------------------
module nnh_dist_pipe (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [nnh_pkg::ADDR_W-1:0] i_addr,
    input  nnh_pkg::t_entry            i_cand,
    input  nnh_pkg::t_entry            i_point,
    input  logic [nnh_pkg::ADDR_W-1:0] i_point_addr,
    output logic                       o_valid,
    output logic [nnh_pkg::DSQ_W-1:0]  o_dsq
);
    import nnh_pkg::*;

    logic              near;
    logic [SPAN_W-1:0] d_z, d_y, d_x;
    logic              r_va, r_vb;
    logic [SPAN_W-1:0] r_az, r_ay, r_ax;
    logic [DSQ_W-1:0]  r_sz, r_sy, r_sx;

    function automatic logic close(input logic [CELL_W-1:0] p, input logic [CELL_W-1:0] q);
        return ((p > q) ? (p - q) : (q - p)) <= CELL_W'(1);
    endfunction

    function automatic logic [SPAN_W-1:0] absdiff(input logic signed [COORD_W-1:0] p,
                                                  input logic signed [COORD_W-1:0] q);
        logic signed [SPAN_W-1:0] d;
        d = SPAN_W'(p) - SPAN_W'(q);
        return d[SPAN_W-1] ? (~d + SPAN_W'(1)) : d;
    endfunction

    always_comb begin
        near = (i_addr != i_point_addr) && close(i_cand.cell_z, i_point.cell_z)
               && close(i_cand.cell_y, i_point.cell_y) && close(i_cand.cell_x, i_point.cell_x);
        d_z = absdiff(i_cand.z, i_point.z);
        d_y = absdiff(i_cand.y, i_point.y);
        d_x = absdiff(i_cand.x, i_point.x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_va    <= i_valid && near;
            r_vb    <= r_va;
            o_valid <= r_vb;
        end
        r_az  <= d_z;
        r_ay  <= d_y;
        r_ax  <= d_x;
        r_sz  <= DSQ_W'(r_az * r_az);
        r_sy  <= DSQ_W'(r_ay * r_ay);
        r_sx  <= DSQ_W'(r_ax * r_ax);
        o_dsq <= r_sz + r_sy + r_sx;
    end

endmodule
